>>> design/ptts_pkg.sv
`default_nettype none

package ptts_pkg;

	localparam int TableDepthDef = 16;
	localparam int TimeBitsDef   = 32;

	// tasks fired per tick at most
	localparam int MAX_RESULTS = 16;
	localparam int NUM_W       = $clog2(MAX_RESULTS + 1);

	localparam logic KIND_TICK = 1'b0;
	localparam logic KIND_ADD  = 1'b1;

	typedef enum logic [1:0] {
		ST_FIRED = 2'd0,
		ST_ADDED = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic        kind;
		logic [15:0] delay;
		logic [15:0] period;
		logic [7:0]  task_tag;
	} in_item_t;

	typedef struct packed {
		status_t    status;
		logic [7:0] fired_tag;
		logic       last;
	} out_item_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ADD_SCAN,
		S_ADD_PUT,
		S_TICK_SCAN,
		S_TICK_DEC,
		S_TICK_LAST
	} state_t;

endpackage

`default_nettype wire

>>> design/periodic_timer_task_scheduler.sv
// channel   direction  handshake              payload
// in        input      in_valid / in_ready    in_item  (in_item_t)
// out       output     out_valid / out_ready  out_item (out_item_t)
// cfg       input      cfg_we, no wait        cfg_wdata (enabled)
//
// One item at a time. An add walks the valid bits one slot a cycle to find a free slot; a
// tick while disabled only advances time; a tick while enabled runs one search per fired
// task plus a final search that finds none, one search less once the count of fired tasks
// reaches MAX_RESULTS; each search reads the memory one slot a cycle.
// Reset empties the table at once (valid flops), no clearing pass. A stalled output holds
// the next firing and the final result of the item until the waiting item is taken.
`default_nettype none

module periodic_timer_task_scheduler
	import ptts_pkg::*;
#(
	parameter int TABLE_DEPTH = TableDepthDef,
	parameter int TIME_BITS   = TimeBitsDef
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire in_item_t  in_item,
	output logic           out_valid,
	input  wire logic      out_ready,
	output out_item_t      out_item,
	input  wire logic      cfg_we,
	input  wire logic      cfg_wdata
);

	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int ENT_W = TIME_BITS + 16 + 8;
	localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(TABLE_DEPTH);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);
	localparam logic [NUM_W-1:0] NUM_MAX  = NUM_W'(MAX_RESULTS);

	state_t state_q, state_d;

	logic [TIME_BITS-1:0] time_q;
	logic                 enabled_q;
	logic                 valid_q [TABLE_DEPTH];

	// entry: {deadline, period, tag}
	logic [ENT_W-1:0]     mem [TABLE_DEPTH];
	logic [ENT_W-1:0]     rd_data_s1;
	logic [IDX_W-1:0]     rd_idx_s1;
	logic                 rd_vld_s1;

	logic [CNT_W-1:0]     cnt_q;
	in_item_t             req_q;
	status_t              add_status_q;

	logic                 best_found_q;
	logic [TIME_BITS-1:0] best_age_q;
	logic [IDX_W-1:0]     best_idx_q;
	logic [15:0]          best_per_q;
	logic [7:0]           best_tag_q;

	logic                 pend_q;
	logic [7:0]           pend_tag_q;
	logic [NUM_W-1:0]     n_q;

	logic                 out_valid_q;
	out_item_t            out_q;

	logic                 accept;
	logic                 can_load;
	logic [IDX_W-1:0]     cnt_idx;
	logic                 add_free;
	logic                 issue;
	logic                 scan_done;
	logic [TIME_BITS-1:0] rd_dl;
	logic [15:0]          rd_per;
	logic [7:0]           rd_tag;
	logic [TIME_BITS-1:0] age;
	logic                 better;
	logic                 dec_go;
	logic [NUM_W-1:0]     n_next;

	logic                 emit;
	out_item_t            emit_item;
	logic                 mem_we;
	logic [IDX_W-1:0]     mem_wa;
	logic [ENT_W-1:0]     mem_wd;
	logic                 vld_set;
	logic                 vld_clr;
	logic                 fire;

	assign accept    = in_valid && in_ready;
	assign can_load  = !out_valid_q || out_ready;
	assign cnt_idx   = cnt_q[IDX_W-1:0];
	assign add_free  = !valid_q[cnt_idx];
	assign issue     = (state_q == S_TICK_SCAN) && (cnt_q != CNT_END);
	assign scan_done = (cnt_q == CNT_END) && !rd_vld_s1;

	assign rd_dl  = rd_data_s1[ENT_W-1 -: TIME_BITS];
	assign rd_per = rd_data_s1[23:8];
	assign rd_tag = rd_data_s1[7:0];

	// due when (now - deadline) has its top bit clear; larger age wins,
	// strict compare keeps the lower slot on ties
	assign age    = time_q - rd_dl;
	assign better = rd_vld_s1 && valid_q[rd_idx_s1] && !age[TIME_BITS-1] &&
	                (!best_found_q || (age > best_age_q));

	// a pending result must leave before the next one takes its place
	assign dec_go = !pend_q || can_load;
	assign n_next = n_q + NUM_W'(1);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (in_item.kind == KIND_ADD) begin
						state_d = S_ADD_SCAN;
					end else if (enabled_q) begin
						state_d = S_TICK_SCAN;
					end
				end
			end
			S_ADD_SCAN: begin
				if (add_free || (cnt_idx == LAST_IDX)) begin
					state_d = S_ADD_PUT;
				end
			end
			S_ADD_PUT: begin
				if (can_load) begin
					state_d = S_IDLE;
				end
			end
			S_TICK_SCAN: begin
				if (scan_done) begin
					state_d = S_TICK_DEC;
				end
			end
			S_TICK_DEC: begin
				if (!best_found_q) begin
					state_d = pend_q ? S_TICK_LAST : S_IDLE;
				end else if (dec_go) begin
					state_d = (n_next == NUM_MAX) ? S_TICK_LAST : S_TICK_SCAN;
				end
			end
			S_TICK_LAST: begin
				if (can_load) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		emit      = 1'b0;
		emit_item = '{status: ST_FIRED, fired_tag: pend_tag_q, last: 1'b0};
		mem_we    = 1'b0;
		mem_wa    = cnt_idx;
		mem_wd    = {time_q + {{(TIME_BITS-16){1'b0}}, req_q.delay},
		             req_q.period, req_q.task_tag};
		vld_set   = 1'b0;
		vld_clr   = 1'b0;
		fire      = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
			end
			S_ADD_SCAN: begin
				if (add_free) begin
					mem_we  = 1'b1;
					vld_set = 1'b1;
				end
			end
			S_ADD_PUT: begin
				emit      = can_load;
				emit_item = '{status: add_status_q, fired_tag: req_q.task_tag, last: 1'b1};
			end
			S_TICK_SCAN: begin
			end
			S_TICK_DEC: begin
				if (best_found_q && dec_go) begin
					fire   = 1'b1;
					emit   = pend_q;
					mem_wa = best_idx_q;
					mem_wd = {time_q + {{(TIME_BITS-16){1'b0}}, best_per_q},
					          best_per_q, best_tag_q};
					if (best_per_q != 16'd0) begin
						mem_we = 1'b1;
					end else begin
						vld_clr = 1'b1;
					end
				end
			end
			S_TICK_LAST: begin
				emit      = can_load;
				emit_item = '{status: ST_FIRED, fired_tag: pend_tag_q, last: 1'b1};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			time_q       <= '0;
			enabled_q    <= 1'b0;
			rd_vld_s1    <= 1'b0;
			cnt_q        <= '0;
			best_found_q <= 1'b0;
			pend_q       <= 1'b0;
			n_q          <= '0;
			out_valid_q  <= 1'b0;
			for (int i = 0; i < TABLE_DEPTH; i++) begin
				valid_q[i] <= 1'b0;
			end
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= issue;
			if (cfg_we) begin
				enabled_q <= cfg_wdata;
			end
			if (accept && (in_item.kind == KIND_TICK)) begin
				time_q <= time_q + TIME_BITS'(1);
			end
			if (accept || fire) begin
				cnt_q <= '0;
			end else if (issue || ((state_q == S_ADD_SCAN) && !add_free)) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (accept || fire) begin
				best_found_q <= 1'b0;
			end else if (better) begin
				best_found_q <= 1'b1;
			end
			if (accept) begin
				pend_q <= 1'b0;
				n_q    <= '0;
			end else if (fire) begin
				pend_q <= 1'b1;
				n_q    <= n_next;
			end
			if (vld_set) begin
				valid_q[mem_wa] <= 1'b1;
			end
			if (vld_clr) begin
				valid_q[best_idx_q] <= 1'b0;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (issue) begin
			rd_data_s1 <= mem[cnt_idx];
			rd_idx_s1  <= cnt_idx;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= in_item;
		end
		if (state_q == S_ADD_SCAN) begin
			add_status_q <= add_free ? ST_ADDED : ST_FULL;
		end
		if (better) begin
			best_age_q <= age;
			best_idx_q <= rd_idx_s1;
			best_per_q <= rd_per;
			best_tag_q <= rd_tag;
		end
		if (fire) begin
			pend_tag_q <= best_tag_q;
		end
		if (emit) begin
			out_q <= emit_item;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

`default_nettype wire

>>> design/ptts_checker.sv
`default_nettype none

module ptts_checker
	import ptts_pkg::*;
(
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      in_valid,
	input wire logic      in_ready,
	input wire in_item_t  in_item,
	input wire logic      out_valid,
	input wire logic      out_ready,
	input wire out_item_t out_item
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("output item changed while stalled");

	// an add answers with exactly one result, so it closes its own item
	a_add_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_item.status != ST_FIRED) |-> out_item.last)
		else $error("add result without last");

	// in the cycle after an add is taken, the slot search holds input off
	a_add_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (in_item.kind == KIND_ADD) |=> !in_ready)
		else $error("input taken right after an add");

	// while a tick still has results to give, no new item is taken
	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.last |-> !in_ready)
		else $error("input ready in the middle of a tick");

endmodule

bind periodic_timer_task_scheduler ptts_checker u_ptts_checker (.*);

`default_nettype wire

>>> dv/timer_sched_checker.sv
`timescale 1ns / 1ps

module timer_sched_checker
	import ptts_pkg::*;
#(
	parameter int TABLE_DEPTH = TableDepthDef,
	parameter int TIME_BITS   = TimeBitsDef
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	input  wire logic      in_ready,
	input  wire in_item_t  in_item,
	input  wire logic      out_valid,
	input  wire logic      out_ready,
	input  wire out_item_t out_item,
	input  wire logic      cfg_we,
	input  wire logic      cfg_wdata,
	output int             fail_count,
	output int             events_owed
);

	// shadow copy of the timer table
	logic [TIME_BITS-1:0] sched_time;
	logic                 sched_en;
	logic                 slot_used   [TABLE_DEPTH];
	logic [TIME_BITS-1:0] slot_due    [TABLE_DEPTH];
	logic [15:0]          slot_reload [TABLE_DEPTH];
	logic [7:0]           slot_tag    [TABLE_DEPTH];

	out_item_t pending_events[$];
	out_item_t want;
	int        mism;

	task automatic run_timer_step(input in_item_t it);
		int             i;
		int             slot;
		int             best;
		int             fired;
		logic [TIME_BITS-1:0] age;
		logic [TIME_BITS-1:0] best_age;
		out_item_t      ev;

		if (it.kind == KIND_ADD) begin
			slot = -1;
			for (i = 0; i < TABLE_DEPTH; i++)
				if (!slot_used[i] && slot < 0)
					slot = i;
			ev.fired_tag = it.task_tag;
			ev.last      = 1'b1;
			if (slot >= 0) begin
				slot_used[slot]   = 1'b1;
				slot_due[slot]    = sched_time + TIME_BITS'(it.delay);
				slot_reload[slot] = it.period;
				slot_tag[slot]    = it.task_tag;
				ev.status         = ST_ADDED;
			end else begin
				ev.status = ST_FULL;
			end
			pending_events.push_back(ev);
		end else begin
			sched_time = sched_time + 1'b1;
			if (sched_en) begin
				fired = 0;
				best  = 0;
				while (fired < MAX_RESULTS && best >= 0) begin
					best     = -1;
					best_age = '0;
					// oldest overdue task wins, lower slot on ties
					for (i = 0; i < TABLE_DEPTH; i++) begin
						if (slot_used[i]) begin
							age = sched_time - slot_due[i];
							if (!age[TIME_BITS-1] && (best < 0 || age > best_age)) begin
								best     = i;
								best_age = age;
							end
						end
					end
					if (best >= 0) begin
						ev.status    = ST_FIRED;
						ev.fired_tag = slot_tag[best];
						ev.last      = 1'b0;
						pending_events.push_back(ev);
						fired++;
						if (slot_reload[best] != 16'd0)
							slot_due[best] = sched_time + TIME_BITS'(slot_reload[best]);
						else
							slot_used[best] = 1'b0;
					end
				end
				if (fired > 0) begin
					ev      = pending_events.pop_back();
					ev.last = 1'b1;
					pending_events.push_back(ev);
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sched_time = '0;
			sched_en   = 1'b0;
			foreach (slot_used[j])
				slot_used[j] = 1'b0;
			pending_events.delete();
			mism = 0;
			fail_count  <= 0;
			events_owed <= 0;
		end else begin
			if (cfg_we)
				sched_en = cfg_wdata;
			if (in_valid && in_ready)
				run_timer_step(in_item);
			if (out_valid && out_ready) begin
				if (pending_events.size() == 0) begin
					mism++;
					if (mism <= 10)
						$display("unexpected result: status %0d tag %02h last %0d",
							out_item.status, out_item.fired_tag, out_item.last);
				end else begin
					want = pending_events.pop_front();
					if (out_item.status !== want.status || out_item.fired_tag !== want.fired_tag
						|| out_item.last !== want.last) begin
						mism++;
						if (mism <= 10)
							$display("mismatch: status exp %0d got %0d, tag exp %02h got %02h, last exp %0d got %0d",
								want.status, out_item.status, want.fired_tag, out_item.fired_tag,
								want.last, out_item.last);
					end
				end
			end
			fail_count  <= mism;
			events_owed <= pending_events.size();
		end
	end

endmodule

>>> dv/tb_periodic_timer_task_scheduler.sv
`timescale 1ns / 1ps

module tb_periodic_timer_task_scheduler;
	import ptts_pkg::*;

	localparam int IDLE_NONE = 0;
	localparam int IDLE_SEND = 1;
	localparam int IDLE_RECV = 2;
	localparam int IDLE_BOTH = 3;

	localparam int PHASE_ITEMS = 72;
	localparam int HOLD_CYCLES = 400;
	localparam int SETTLE      = 64;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_item_t  in_item;
	logic      out_valid;
	logic      out_ready;
	out_item_t out_item;
	logic      cfg_we;
	logic      cfg_wdata;

	int   fail_count;
	int   events_owed;
	int   idle_mode = IDLE_NONE;
	logic hold_go   = 1'b0;
	logic hold_done = 1'b0;

	periodic_timer_task_scheduler u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	timer_sched_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_item     (in_item),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_item    (out_item),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.fail_count  (fail_count),
		.events_owed (events_owed)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("FAIL");
		$finish;
	end

	// result side: random stalls per mode, one long hold-off on request
	initial begin
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_go && !hold_done) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
			end
			out_ready <= ($urandom_range(99) >= (idle_mode == IDLE_RECV ? 76 :
				idle_mode == IDLE_BOTH ? 12 : 0));
		end
	end

	function automatic in_item_t mk_item(logic k, logic [15:0] d, logic [15:0] p,
		logic [7:0] t);
		in_item_t it;
		it.kind     = k;
		it.delay    = d;
		it.period   = p;
		it.task_tag = t;
		return it;
	endfunction

	// short delays keep tasks firing; rare full-range values cover the upper bits
	function automatic in_item_t rand_item();
		in_item_t it;
		it.kind     = ($urandom_range(99) < 45) ? KIND_ADD : KIND_TICK;
		it.delay    = ($urandom_range(99) < 4) ? 16'($urandom_range(65535))
			: 16'($urandom_range(12));
		it.period   = 16'd0;
		if ($urandom_range(99) < 15)
			it.period = ($urandom_range(99) < 20) ? 16'($urandom_range(65535))
				: 16'($urandom_range(1, 30));
		it.task_tag = 8'($urandom_range(255));
		return it;
	endfunction

	// valid stays high after acceptance; the next call or a gap decides
	task automatic offer_item(input in_item_t it);
		in_item  <= it;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic sender_gap();
		while ($urandom_range(99) < (idle_mode == IDLE_SEND ? 76 :
			idle_mode == IDLE_BOTH ? 12 : 0)) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (events_owed != 0)
			@(posedge clk);
		// a quiet tick may still be scanning
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_enable(input logic v);
		drain_results();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	initial begin
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		in_item   <= '0;
		cfg_we    <= 1'b0;
		cfg_wdata <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// tick while disabled: nothing fires
		offer_item(mk_item(KIND_TICK, 16'hFFFF, 16'hFFFF, 8'hFF));
		set_enable(1'b1);
		// zero delay fires on the next tick
		offer_item(mk_item(KIND_ADD, 16'd0, 16'd0, 8'h00));
		offer_item(mk_item(KIND_TICK, 16'd0, 16'd0, 8'h00));
		offer_item(mk_item(KIND_ADD, 16'hFFFF, 16'hFFFF, 8'hFF));
		// equal deadlines: lower slot first; older deadline ahead of both
		offer_item(mk_item(KIND_ADD, 16'd2, 16'd3, 8'hA5));
		offer_item(mk_item(KIND_ADD, 16'd2, 16'd0, 8'h5A));
		offer_item(mk_item(KIND_ADD, 16'd1, 16'd0, 8'h11));
		repeat (3) offer_item(mk_item(KIND_TICK, 16'd0, 16'd0, 8'h00));
		// fill the table, one add past full is rejected, then a burst fires
		repeat (15) offer_item(mk_item(KIND_ADD, 16'd4, 16'd0, 8'($urandom_range(255))));
		repeat (4) offer_item(mk_item(KIND_TICK, 16'd0, 16'd0, 8'h00));

		for (int p = IDLE_NONE; p <= IDLE_BOTH; p++) begin
			// disabled during one phase so tasks pile up overdue
			set_enable(p == IDLE_SEND ? 1'b0 : 1'b1);
			idle_mode = p;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (p == IDLE_NONE && n == 40)
					hold_go = 1'b1;
				if (p == IDLE_RECV && n == 40)
					drain_results();
				sender_gap();
				offer_item(rand_item());
			end
		end

		drain_results();
		if (fail_count == 0 && events_owed == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
